// ===== design/signed_int_to_decimal_ascii_core_defines.svh =====
// assertion macros shared by the checker
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// clocked check, quiet while reset is asserted
`define SIDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds during reset
`define SIDC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/sidc_pkg.sv =====
package sidc_pkg;

  localparam int unsigned VALUE_WIDTH_DEFAULT = 32;
  localparam int unsigned BITS_PER_STAGE      = 4;
  localparam int unsigned RADIX               = 10;

  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;

  // decimal digits needed for the largest magnitude, 2**(w-1)
  function automatic int unsigned num_digits(input int unsigned w);
    logic [71:0] lim;
    logic [71:0] p;
    int unsigned n;
    lim = 72'd1 << (w - 1);
    p   = 72'd1;
    n   = 0;
    for (int i = 0; i < 24; i++) begin
      if (p <= lim) begin
        n = n + 1;
        p = p * 72'(RADIX);
      end
    end
    return n;
  endfunction

endpackage

// ===== design/sidc_dabble_stage.sv =====
module sidc_dabble_stage #(
  parameter int unsigned BCD_W = 40,
  parameter int unsigned BIN_W = 32,
  parameter int unsigned STEPS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [BCD_W-1:0] in_bcd_i,
  input  logic [BIN_W-1:0] in_bin_i,
  input  logic             in_neg_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [BCD_W-1:0] out_bcd_o,
  output logic [BIN_W-1:0] out_bin_o,
  output logic             out_neg_o
);

  localparam int unsigned NDIG = BCD_W / 4;

  logic             valid_q;
  logic [BCD_W-1:0] bcd_d, bcd_q;
  logic [BIN_W-1:0] bin_d, bin_q;
  logic             neg_q;

  // add-3 and shift, STEPS bits per stage
  always_comb begin
    logic [BCD_W-1:0] b;
    logic [BIN_W-1:0] r;
    b = in_bcd_i;
    r = in_bin_i;
    for (int s = 0; s < STEPS; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (b[4*d +: 4] >= 4'd5) begin
          b[4*d +: 4] = b[4*d +: 4] + 4'd3;
        end
      end
      b = {b[BCD_W-2:0], r[BIN_W-1]};
      r = {r[BIN_W-2:0], 1'b0};
    end
    bcd_d = b;
    bin_d = r;
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      bcd_q <= bcd_d;
      bin_q <= bin_d;
      neg_q <= in_neg_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_bcd_o   = bcd_q;
  assign out_bin_o   = bin_q;
  assign out_neg_o   = neg_q;

endmodule

// ===== design/signed_int_to_decimal_ascii_core.sv =====
// signed integer to decimal ascii text, one character per output transaction
// pipeline: the input passes a sign stage, NS = ceil(VALUE_WIDTH/4) conversion stages,
//   a leading digit stage and the output sequencer before its first character
// output: each number holds the single character output port for one transaction per
//   character, 1 to 11 characters at 32 bits; the stages keep filling meanwhile
// reset: asynchronous active low, clears every valid bit and the output sequencer
module signed_int_to_decimal_ascii_core #(
  parameter int unsigned VALUE_WIDTH = sidc_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [7:0]             character_o,
  output logic                   last_o
);

  // sizing, all from the value width
  localparam int unsigned ND    = sidc_pkg::num_digits(VALUE_WIDTH);
  localparam int unsigned BCD_W = 4 * ND;
  localparam int unsigned BPS   = sidc_pkg::BITS_PER_STAGE;
  localparam int unsigned NS    = (VALUE_WIDTH + BPS - 1) / BPS;
  localparam int unsigned BIN_W = NS * BPS;
  localparam int unsigned POS_W = (ND > 1) ? $clog2(ND) : 1;

  // ---------------------------------------------------------------
  // stage 0: sign and magnitude; the most negative value negates to
  // 2**(w-1), which still fits the unsigned w-bit magnitude
  // ---------------------------------------------------------------
  logic                   s0_valid_q;
  logic                   s0_neg_q;
  logic [VALUE_WIDTH-1:0] s0_mag_d, s0_mag_q;
  logic                   s0_ready;

  assign s0_mag_d = value_i[VALUE_WIDTH-1] ? (~value_i + 1'b1) : value_i;
  assign ready_o  = !s0_valid_q || s0_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (ready_o) begin
      s0_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      s0_mag_q <= s0_mag_d;
      s0_neg_q <= value_i[VALUE_WIDTH-1];
    end
  end

  // ---------------------------------------------------------------
  // double-dabble conversion chain, four magnitude bits per stage
  // ---------------------------------------------------------------
  logic [NS:0]      ch_valid;
  logic [NS:0]      ch_ready;
  logic [NS:0]      ch_neg;
  logic [BCD_W-1:0] ch_bcd [NS+1];
  logic [BIN_W-1:0] ch_bin [NS+1];

  assign ch_valid[0] = s0_valid_q;
  assign ch_neg[0]   = s0_neg_q;
  assign ch_bcd[0]   = '0;
  assign ch_bin[0]   = BIN_W'(s0_mag_q);
  assign s0_ready    = ch_ready[0];

  for (genvar g = 0; g < NS; g++) begin : g_stage
    sidc_dabble_stage #(
      .BCD_W (BCD_W),
      .BIN_W (BIN_W),
      .STEPS (BPS)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (ch_valid[g]),
      .in_ready_o  (ch_ready[g]),
      .in_bcd_i    (ch_bcd[g]),
      .in_bin_i    (ch_bin[g]),
      .in_neg_i    (ch_neg[g]),
      .out_valid_o (ch_valid[g+1]),
      .out_ready_i (ch_ready[g+1]),
      .out_bcd_o   (ch_bcd[g+1]),
      .out_bin_o   (ch_bin[g+1]),
      .out_neg_o   (ch_neg[g+1])
    );
  end

  // ---------------------------------------------------------------
  // leading digit stage: position of the highest non-zero digit,
  // zero itself keeps position 0 and so prints a single '0'
  // ---------------------------------------------------------------
  logic             cnt_valid_q;
  logic             cnt_neg_q;
  logic [BCD_W-1:0] cnt_bcd_q;
  logic [POS_W-1:0] cnt_pos_d, cnt_pos_q;
  logic             ser_ready;

  always_comb begin
    cnt_pos_d = '0;
    for (int i = 0; i < ND; i++) begin
      if (ch_bcd[NS][4*i +: 4] != 4'd0) begin
        cnt_pos_d = POS_W'(i);
      end
    end
  end

  assign ch_ready[NS] = !cnt_valid_q || ser_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_valid_q <= 1'b0;
    end else if (ch_ready[NS]) begin
      cnt_valid_q <= ch_valid[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ch_ready[NS] && ch_valid[NS]) begin
      cnt_bcd_q <= ch_bcd[NS];
      cnt_pos_q <= cnt_pos_d;
      cnt_neg_q <= ch_neg[NS];
    end
  end

  // ---------------------------------------------------------------
  // output sequencer: optional minus sign, then digits from the
  // leading one down to the units digit; the next number loads as
  // the last character of this one is taken
  // ---------------------------------------------------------------
  logic             ser_busy_q;
  logic             ser_minus_q;
  logic [POS_W-1:0] ser_pos_q;
  logic [BCD_W-1:0] ser_bcd_q;
  logic             ser_load;
  logic [3:0]       ser_digit;

  assign ser_ready = !ser_busy_q || (ready_i && last_o);
  assign ser_load  = cnt_valid_q && ser_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_busy_q  <= 1'b0;
      ser_minus_q <= 1'b0;
      ser_pos_q   <= '0;
    end else if (ser_load) begin
      ser_busy_q  <= 1'b1;
      ser_minus_q <= cnt_neg_q;
      ser_pos_q   <= cnt_pos_q;
    end else if (ser_busy_q && ready_i) begin
      if (ser_minus_q) begin
        ser_minus_q <= 1'b0;
      end else if (ser_pos_q == '0) begin
        ser_busy_q <= 1'b0;
      end else begin
        ser_pos_q <= ser_pos_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_load) begin
      ser_bcd_q <= cnt_bcd_q;
    end
  end

  assign ser_digit   = ser_bcd_q[4*ser_pos_q +: 4];
  assign valid_o     = ser_busy_q;
  assign last_o      = ser_busy_q && !ser_minus_q && (ser_pos_q == '0);
  assign character_o = ser_minus_q ? sidc_pkg::CHAR_MINUS
                                   : (sidc_pkg::CHAR_ZERO + {4'b0000, ser_digit});

endmodule

// ===== design/sidc_checker.sv =====
`include "signed_int_to_decimal_ascii_core_defines.svh"

module sidc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_o,
  input logic       ready_i,
  input logic [7:0] character_o,
  input logic       last_o
);

  logic is_minus;
  logic is_digit;
  logic is_lead;
  logic minus_taken;

  assign is_minus    = (character_o == sidc_pkg::CHAR_MINUS);
  assign is_digit    = (character_o >= sidc_pkg::CHAR_ZERO) &&
                       (character_o <= (sidc_pkg::CHAR_ZERO + 8'd9));
  assign is_lead     = is_digit && (character_o != sidc_pkg::CHAR_ZERO);
  assign minus_taken = valid_o && ready_i && is_minus;

  // output held until taken
  `SIDC_ASSERT(a_valid_hold, valid_o && !ready_i |=> valid_o, "output dropped while stalled")

  `SIDC_ASSERT(a_char_legal, valid_o |-> (is_minus || is_digit), "illegal character")

  // a minus sign is never the whole text
  `SIDC_ASSERT(a_minus_not_last, valid_o && is_minus |-> !last_o, "minus sign marked last")

  // a negative number has a non-zero leading digit right after its sign
  `SIDC_ASSERT(a_digit_after_minus, minus_taken |=> valid_o && is_lead, "bad digit after minus")

  // the output is quiet from the edge after reset is seen
  `SIDC_ASSERT_RST(a_reset_idle, !rst_ni |=> !valid_o, "output valid during reset")

endmodule

bind signed_int_to_decimal_ascii_core sidc_checker u_sidc_checker (.*);
